@@ hw/rtl/dmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg: shared definitions for the direct-mapped write-back cache
// Geometry constants, derived field widths and the controller state type.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Cache geometry. NUM_SETS and BLOCK_WORDS are powers of two.
  localparam int NUM_SETS    = 16;
  localparam int BLOCK_WORDS = 8;
  localparam int ADDR_W      = 12;
  localparam int MEM_WORDS   = 1 << ADDR_W;

  localparam int DATA_W = 32;
  localparam int OFF_W  = $clog2(BLOCK_WORDS);
  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int TAG_W  = ADDR_W - OFF_W - SET_W;
  localparam int LINE_AW = SET_W + OFF_W;
  localparam int LINE_WORDS = NUM_SETS * BLOCK_WORDS;

  // Word counter for write-back and fill sweeps; it must reach BLOCK_WORDS.
  localparam int CNT_W = OFF_W + 1;
  localparam logic [CNT_W-1:0] BLK_END = CNT_W'(BLOCK_WORDS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WB,
    ST_FILL,
    ST_RDLINE,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/dmc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/direct_mapped_writeback_cache.sv @@
`timescale 1ns / 1ps
// Hit: lookup in ST_IDLE, then the update in ST_FINISH, before the next acceptance.
// Clean miss: ST_FILL, ST_RDLINE, then ST_FINISH; the fill sweep moves one word a cycle.
// Dirty miss: ST_WB before the clean-miss steps; write-back and fill each sweep
// the line through the single read port of the line store and of main memory.
// The result is registered and appears the cycle after the final step.
// After reset, all MEM_WORDS words of main memory are cleared before any beat is taken.
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache: direct-mapped write-back write-allocate cache
// Line data and main memory sit in synchronous RAMs; tags, valid and dirty
// bits and the access counters sit in flip-flops.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [dmc_pkg::ADDR_W-1:0]  in_addr,
  input  logic [dmc_pkg::DATA_W-1:0]  in_write_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dmc_pkg::DATA_W-1:0]  out_read_data,
  output logic                        out_hit,
  output logic                        out_wrote_back,
  output logic [31:0]                 out_read_count,
  output logic [31:0]                 out_read_miss_count,
  output logic [31:0]                 out_write_count,
  output logic [31:0]                 out_write_miss_count
);

  import dmc_pkg::*;

  // Controller state and sweep counters.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;

  // Per-line bookkeeping. Valid and dirty reset; tags are payload.
  logic [NUM_SETS-1:0] valid_r, valid_nxt;
  logic [NUM_SETS-1:0] dirty_r, dirty_nxt;
  logic [TAG_W-1:0]    tag_mem_r [NUM_SETS];
  logic                tag_we;

  // The item in flight.
  logic               op_r, op_nxt;
  logic [SET_W-1:0]   set_r, set_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [DATA_W-1:0]  wdata_r, wdata_nxt;
  logic [TAG_W-1:0]   vtag_r, vtag_nxt;
  logic               hit_r, hit_nxt;
  logic               wb_r, wb_nxt;

  // Access counters: loads, load misses, stores, store misses.
  logic [31:0] rd_cnt_r, rd_cnt_nxt;
  logic [31:0] rdm_cnt_r, rdm_cnt_nxt;
  logic [31:0] wr_cnt_r, wr_cnt_nxt;
  logic [31:0] wrm_cnt_r, wrm_cnt_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_rdata_r, out_rdata_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_wb_r, out_wb_nxt;

  // Memory ports.
  logic               line_we, line_re;
  logic [LINE_AW-1:0] line_waddr, line_raddr;
  logic [DATA_W-1:0]  line_wdata, line_rdata;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0]  mem_wdata, mem_rdata;

  // Address fields of the incoming beat.
  logic [SET_W-1:0]   in_set;
  logic [TAG_W-1:0]   in_tag;
  logic [OFF_W-1:0]   in_off;
  logic               in_hit;
  logic [OFF_W-1:0]   cnt_lo, cnt_prev;
  logic               slot_free;

  assign in_off = in_addr[OFF_W-1:0];
  assign in_set = in_addr[OFF_W+SET_W-1:OFF_W];
  assign in_tag = in_addr[ADDR_W-1:OFF_W+SET_W];
  assign in_hit = valid_r[in_set] && (tag_mem_r[in_set] == in_tag);

  // The sweep counter runs one ahead of the write side: reads are issued at
  // cnt and their data lands in the next cycle at word cnt - 1.
  assign cnt_lo   = cnt_r[OFF_W-1:0];
  assign cnt_prev = OFF_W'(cnt_r - CNT_W'(1));

  // The output slot can take a new beat when it is empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  dmc_ram #(
    .DEPTH (LINE_WORDS),
    .WIDTH (DATA_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  dmc_ram #(
    .DEPTH (MEM_WORDS),
    .WIDTH (DATA_W)
  ) u_main_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    tag_we        = 1'b0;
    op_nxt        = op_r;
    set_nxt       = set_r;
    tag_nxt       = tag_r;
    off_nxt       = off_r;
    wdata_nxt     = wdata_r;
    vtag_nxt      = vtag_r;
    hit_nxt       = hit_r;
    wb_nxt        = wb_r;
    rd_cnt_nxt    = rd_cnt_r;
    rdm_cnt_nxt   = rdm_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;
    wrm_cnt_nxt   = wrm_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rdata_nxt = out_rdata_r;
    out_hit_nxt   = out_hit_r;
    out_wb_nxt    = out_wb_r;
    in_ready      = 1'b0;
    line_we       = 1'b0;
    line_waddr    = {set_r, off_r};
    line_wdata    = wdata_r;
    line_re       = 1'b0;
    line_raddr    = {set_r, off_r};
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = {tag_r, set_r, cnt_lo};

    unique case (state_r)
      ST_CLEAR: begin
        // Zero main memory one word per cycle.
        mem_we  = 1'b1;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_op;
          set_nxt   = in_set;
          tag_nxt   = in_tag;
          off_nxt   = in_off;
          wdata_nxt = in_write_data;
          hit_nxt   = in_hit;
          cnt_nxt   = '0;
          if (in_hit) begin
            // Hit: fetch the word now, finish in ST_FINISH once the slot is free.
            line_re    = 1'b1;
            line_raddr = {in_set, in_off};
            wb_nxt     = 1'b0;
            state_nxt  = ST_FINISH;
          end else begin
            // Miss: the line is reallocated now; the old tag is kept for the
            // write-back, whose data is still in the line store.
            vtag_nxt          = tag_mem_r[in_set];
            wb_nxt            = valid_r[in_set] && dirty_r[in_set];
            tag_we            = 1'b1;
            valid_nxt[in_set] = 1'b1;
            dirty_nxt[in_set] = 1'b0;
            state_nxt = (valid_r[in_set] && dirty_r[in_set]) ? ST_WB : ST_FILL;
          end
        end
      end

      ST_WB: begin
        line_re    = (cnt_r != BLK_END);
        line_raddr = {set_r, cnt_lo};
        mem_we     = (cnt_r != '0);
        mem_waddr  = {vtag_r, set_r, cnt_prev};
        mem_wdata  = line_rdata;
        if (cnt_r == BLK_END) begin
          cnt_nxt   = '0;
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      ST_FILL: begin
        mem_re     = (cnt_r != BLK_END);
        mem_raddr  = {tag_r, set_r, cnt_lo};
        line_we    = (cnt_r != '0);
        line_waddr = {set_r, cnt_prev};
        line_wdata = mem_rdata;
        if (cnt_r == BLK_END) begin
          state_nxt = ST_RDLINE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      ST_RDLINE: begin
        line_re   = 1'b1;
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        // Hold here until the output register can take the result beat.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_wb_nxt    = wb_r;
          if (op_r) begin
            line_we          = 1'b1;
            dirty_nxt[set_r] = 1'b1;
            out_rdata_nxt    = '0;
            wr_cnt_nxt       = wr_cnt_r + 32'd1;
            if (!hit_r) begin
              wrm_cnt_nxt = wrm_cnt_r + 32'd1;
            end
          end else begin
            out_rdata_nxt = line_rdata;
            rd_cnt_nxt    = rd_cnt_r + 32'd1;
            if (!hit_r) begin
              rdm_cnt_nxt = rdm_cnt_r + 32'd1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      rd_cnt_r    <= '0;
      rdm_cnt_r   <= '0;
      wr_cnt_r    <= '0;
      wrm_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rdm_cnt_r   <= rdm_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      wrm_cnt_r   <= wrm_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    set_r       <= set_nxt;
    tag_r       <= tag_nxt;
    off_r       <= off_nxt;
    wdata_r     <= wdata_nxt;
    vtag_r      <= vtag_nxt;
    hit_r       <= hit_nxt;
    wb_r        <= wb_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_hit_r   <= out_hit_nxt;
    out_wb_r    <= out_wb_nxt;
    if (tag_we) begin
      tag_mem_r[in_set] <= in_tag;
    end
  end

  // The counters change only at the edge that loads the output register,
  // so they can drive the result ports directly.
  assign out_valid            = out_valid_r;
  assign out_read_data        = out_rdata_r;
  assign out_hit              = out_hit_r;
  assign out_wrote_back       = out_wb_r;
  assign out_read_count       = rd_cnt_r;
  assign out_read_miss_count  = rdm_cnt_r;
  assign out_write_count      = wr_cnt_r;
  assign out_write_miss_count = wrm_cnt_r;

  // A hit never evicts, so it never writes back.
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_wrote_back)
    else $error("hit beat reports a write-back");

  // A load miss is always counted as a load as well.
  a_rdm_with_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_read_miss_count != $past(out_read_miss_count))
      |-> out_read_count != $past(out_read_count))
    else $error("load miss counted without a load");

  // A store miss is always counted as a store as well.
  a_wrm_with_wr: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_write_miss_count != $past(out_write_miss_count))
      |-> out_write_count != $past(out_write_count))
    else $error("store miss counted without a store");

endmodule
